// ----- hw/rtl/vtm_pkg.sv -----
// Shared types and constants for the virtual timer multiplexer.
// Holds field widths, action and event codes, and the sequencer state type.
// No dependencies.
package vtm_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF = 32;

	localparam int ACT_W    = 2;
	localparam int DUR_W    = 32;
	localparam int ID_W     = 4;
	localparam int KIND_W   = 3;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK         = 2'd0,
		ACT_START_ONCE   = 2'd1,
		ACT_START_REPEAT = 2'd2,
		ACT_CANCEL       = 2'd3
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		EV_STARTED    = 3'd0,
		EV_TABLE_FULL = 3'd1,
		EV_CANCELLED  = 3'd2,
		EV_NOT_FOUND  = 3'd3,
		EV_EXPIRED    = 3'd4
	} event_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_REARM_RD,
		ST_REARM_WR,
		ST_FREE,
		ST_START,
		ST_CANCEL
	} state_t;

endpackage

// ----- hw/rtl/vtm_slot_mem.sv -----
// Period and deadline storage for the timer slots, one write and one read port.
// Read data is registered. Depends on no package.
module vtm_slot_mem #(
	parameter int NUM_SLOTS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                         clk,
	input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
	input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
	input  logic                         per_we,
	input  logic                         dl_we,
	input  logic [TIME_BITS-1:0]         wr_period,
	input  logic [TIME_BITS-1:0]         wr_deadline,
	output logic [TIME_BITS-1:0]         rd_period,
	output logic [TIME_BITS-1:0]         rd_deadline
);

	logic [TIME_BITS-1:0] period_mem   [NUM_SLOTS];
	logic [TIME_BITS-1:0] deadline_mem [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (per_we) begin
			period_mem[wr_addr] <= wr_period;
		end
		if (dl_we) begin
			deadline_mem[wr_addr] <= wr_deadline;
		end
		rd_period   <= period_mem[rd_addr];
		rd_deadline <= deadline_mem[rd_addr];
	end

endmodule

// ----- hw/rtl/virtual_timer_multiplexer.sv -----
// Top level of the virtual timer multiplexer: slot table, sequencer and shared adder.
// Depends on vtm_pkg and vtm_slot_mem.
//
// Usage. Items arrive on the s_ channel: s_tuser carries the action (tick, start
// one-shot, start repeated, cancel) and s_tdata the duration and the target id.
// Results leave on the m_ channel: m_tuser is the event kind, m_tdata the slot
// id, and m_tlast marks the final result caused by one input item.
// A start scans the valid bits one slot per cycle for the lowest free slot. A tick
// first advances the microsecond counter, then runs one pass over the slot table
// per expiring timer; each pass reads one slot per cycle from the slot memory,
// and a repeated timer is then rearmed by reading its period and writing its new
// deadline. A tick with no due timer runs one pass and gives no result.
// All subtractions and additions on time values go through one shared adder.
// s_tready is high only while the sequencer is idle; one item is handled at a time.
// Results sit in an output register: while the receiver stalls the register holds
// its item and the sequencer waits before loading the next result.
// Reset clears the counter, all valid and repeat marks and the output valid flag;
// the period and deadline memories are not cleared and their contents only matter
// for slots that have been started.
module virtual_timer_multiplexer #(
	parameter int NUM_SLOTS = vtm_pkg::NUM_SLOTS_DEF,
	parameter int TIME_BITS = vtm_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [vtm_pkg::S_DATA_W-1:0] s_tdata,  // duration[31:0], target_id[35:32], zero pad
	input  logic [vtm_pkg::ACT_W-1:0]    s_tuser,  // action[1:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [vtm_pkg::M_DATA_W-1:0] m_tdata,  // slot_id[3:0], zero pad
	output logic [vtm_pkg::KIND_W-1:0]   m_tuser,  // event_kind[2:0]
	output logic                         m_tlast
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int EXT_W = IDX_W + vtm_pkg::ID_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	vtm_pkg::state_t  state_q, state_d;
	vtm_pkg::action_t action_q;
	logic [TIME_BITS-1:0]        dur_q;
	logic [vtm_pkg::ID_W-1:0]    target_q;
	logic [TIME_BITS-1:0]        now_q;
	logic [NUM_SLOTS-1:0]        valid_q, repeat_q, due_q;
	logic [IDX_W-1:0]            cnt_q;
	logic                        first_q, found_q;
	logic [IDX_W-1:0]            best_idx_q;
	logic [TIME_BITS-1:0]        best_late_q, best_dl_q;

	// Scan pipeline: stage 1 is the memory read, stage 2 holds the lateness.
	logic                        v_s1, v_s2;
	logic [IDX_W-1:0]            idx_s1, idx_s2;
	logic [TIME_BITS-1:0]        late_s2, dl_s2;

	logic                        out_valid_q, out_last_q;
	vtm_pkg::event_t             out_kind_q;
	logic [vtm_pkg::ID_W-1:0]    out_id_q;

	// Memory interface.
	logic [IDX_W-1:0]     rd_addr, wr_addr;
	logic                 per_we, dl_we;
	logic [TIME_BITS-1:0] rd_period, rd_deadline;

	// Shared adder.
	logic [TIME_BITS-1:0] add_a, add_b, sum;
	logic                 add_sub;

	logic                     accept, out_free, out_load;
	vtm_pkg::event_t          out_kind_d;
	logic [vtm_pkg::ID_W-1:0] out_id_d;
	logic                     out_last_d;
	logic [EXT_W-1:0]         tgt_ext, pick_ext;
	logic [IDX_W-1:0]         tgt_idx;
	logic                     tgt_hit, cnt_free, cand_s2, better, more;
	logic [NUM_SLOTS-1:0]     remain;

	vtm_slot_mem #(
		.NUM_SLOTS (NUM_SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_slot_mem (
		.clk         (clk),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.per_we      (per_we),
		.dl_we       (dl_we),
		.wr_period   (dur_q),
		.wr_deadline (sum),
		.rd_period   (rd_period),
		.rd_deadline (rd_deadline)
	);

	// Status terms used by the sequencer.
	always_comb begin
		out_free = !out_valid_q || m_tready;
		tgt_ext  = EXT_W'(target_q);
		tgt_idx  = tgt_ext[IDX_W-1:0];
		tgt_hit  = (tgt_ext < EXT_W'(NUM_SLOTS)) && valid_q[tgt_idx];
		pick_ext = EXT_W'(best_idx_q);
		cnt_free = !valid_q[cnt_q];
		// A slot is due when now minus its deadline has a clear top bit.
		// After the first pass the due marks are frozen for this tick, apart from clearing each fired slot.
		cand_s2  = first_q ? (valid_q[idx_s2] && !late_s2[TIME_BITS-1]) : due_q[idx_s2];
		// Strict compare keeps the lower index on equal lateness.
		better   = v_s2 && cand_s2 && (!found_q || late_s2 > best_late_q);
		remain   = due_q & ~(NUM_SLOTS'(1) << best_idx_q);
		more     = |remain;
	end

	// Operand selection for the shared adder.
	always_comb begin
		add_a   = now_q;
		add_b   = rd_deadline;
		add_sub = 1'b1;
		unique case (state_q)
			vtm_pkg::ST_TICK: begin
				add_b   = TIME_BITS'(1);
				add_sub = 1'b0;
			end
			vtm_pkg::ST_START: begin
				add_b   = dur_q;
				add_sub = 1'b0;
			end
			vtm_pkg::ST_REARM_WR: begin
				add_a   = best_dl_q;
				add_b   = rd_period;
				add_sub = 1'b0;
			end
			default: begin
				add_a   = now_q;
				add_b   = rd_deadline;
				add_sub = 1'b1;
			end
		endcase
		sum = add_sub ? (add_a - add_b) : (add_a + add_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control outputs of the sequencer.
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		rd_addr    = cnt_q;
		wr_addr    = best_idx_q;
		per_we     = 1'b0;
		dl_we      = 1'b0;
		out_load   = 1'b0;
		out_kind_d = vtm_pkg::EV_EXPIRED;
		out_id_d   = pick_ext[vtm_pkg::ID_W-1:0];
		out_last_d = 1'b1;
		unique case (state_q)
			vtm_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (vtm_pkg::action_t'(s_tuser))
						vtm_pkg::ACT_TICK:         state_d = vtm_pkg::ST_TICK;
						vtm_pkg::ACT_START_ONCE:   state_d = vtm_pkg::ST_FREE;
						vtm_pkg::ACT_START_REPEAT: state_d = vtm_pkg::ST_FREE;
						vtm_pkg::ACT_CANCEL:       state_d = vtm_pkg::ST_CANCEL;
						default:                   state_d = vtm_pkg::ST_IDLE;
					endcase
				end
			end
			vtm_pkg::ST_TICK: begin
				state_d = vtm_pkg::ST_SCAN;
			end
			vtm_pkg::ST_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = vtm_pkg::ST_DRAIN;
				end
			end
			vtm_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = vtm_pkg::ST_PICK;
				end
			end
			vtm_pkg::ST_PICK: begin
				if (!found_q) begin
					state_d = vtm_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_last_d = !more;
					if (repeat_q[best_idx_q]) begin
						state_d = vtm_pkg::ST_REARM_RD;
					end else if (more) begin
						state_d = vtm_pkg::ST_SCAN;
					end else begin
						state_d = vtm_pkg::ST_IDLE;
					end
				end
			end
			vtm_pkg::ST_REARM_RD: begin
				rd_addr = best_idx_q;
				state_d = vtm_pkg::ST_REARM_WR;
			end
			vtm_pkg::ST_REARM_WR: begin
				dl_we   = 1'b1;
				state_d = more ? vtm_pkg::ST_SCAN : vtm_pkg::ST_IDLE;
			end
			vtm_pkg::ST_FREE: begin
				if (cnt_free || cnt_q == LAST_IDX) begin
					state_d = vtm_pkg::ST_START;
				end
			end
			vtm_pkg::ST_START: begin
				if (out_free) begin
					out_load = 1'b1;
					if (found_q) begin
						per_we     = 1'b1;
						dl_we      = 1'b1;
						out_kind_d = vtm_pkg::EV_STARTED;
					end else begin
						out_kind_d = vtm_pkg::EV_TABLE_FULL;
						out_id_d   = '0;
					end
					state_d = vtm_pkg::ST_IDLE;
				end
			end
			vtm_pkg::ST_CANCEL: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind_d = tgt_hit ? vtm_pkg::EV_CANCELLED : vtm_pkg::EV_NOT_FOUND;
					out_id_d   = target_q;
					state_d    = vtm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vtm_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			valid_q     <= '0;
			repeat_q    <= '0;
			due_q       <= '0;
			cnt_q       <= '0;
			first_q     <= 1'b0;
			found_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == vtm_pkg::ST_SCAN);
			v_s2 <= v_s1;
			if (better) begin
				found_q <= 1'b1;
			end
			if (v_s2 && first_q) begin
				due_q[idx_s2] <= cand_s2;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				vtm_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				vtm_pkg::ST_TICK: begin
					now_q   <= sum;
					first_q <= 1'b1;
				end
				vtm_pkg::ST_SCAN: begin
					cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IDX_W'(1);
				end
				vtm_pkg::ST_PICK: begin
					if (found_q && out_free) begin
						due_q[best_idx_q] <= 1'b0;
						if (!repeat_q[best_idx_q]) begin
							valid_q[best_idx_q] <= 1'b0;
						end
						first_q <= 1'b0;
						found_q <= 1'b0;
					end
				end
				vtm_pkg::ST_FREE: begin
					if (cnt_free) begin
						found_q <= 1'b1;
					end else if (cnt_q != LAST_IDX) begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				vtm_pkg::ST_START: begin
					if (out_free && found_q) begin
						valid_q[best_idx_q]  <= 1'b1;
						repeat_q[best_idx_q] <= (action_q == vtm_pkg::ACT_START_REPEAT);
					end
				end
				vtm_pkg::ST_CANCEL: begin
					if (out_free && tgt_hit) begin
						valid_q[tgt_idx]  <= 1'b0;
						repeat_q[tgt_idx] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= vtm_pkg::action_t'(s_tuser);
			dur_q    <= TIME_BITS'(s_tdata[vtm_pkg::DUR_W-1:0]);
			target_q <= s_tdata[vtm_pkg::DUR_W +: vtm_pkg::ID_W];
		end
		idx_s1  <= cnt_q;
		idx_s2  <= idx_s1;
		late_s2 <= sum;
		dl_s2   <= rd_deadline;
		if (better) begin
			best_idx_q  <= idx_s2;
			best_late_q <= late_s2;
			best_dl_q   <= dl_s2;
		end
		if (state_q == vtm_pkg::ST_FREE && cnt_free) begin
			best_idx_q <= cnt_q;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_id_q   <= out_id_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = vtm_pkg::M_DATA_W'(out_id_q);
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- hw/rtl/vtm_checker.sv -----
// Port-level checks for the virtual timer multiplexer, bound to the top level.
// Depends on vtm_pkg and virtual_timer_multiplexer.
module vtm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [vtm_pkg::M_DATA_W-1:0] m_tdata,
	input logic [vtm_pkg::KIND_W-1:0]   m_tuser,
	input logic                         m_tlast
);

	// One item at a time: the block is busy right after taking an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous item still in work");

	// Start and cancel answers are always the only result of their item.
	a_single_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != vtm_pkg::EV_EXPIRED |-> m_tlast)
		else $error("non-expiry result without last");

	// A full table answers with id zero.
	a_full_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == vtm_pkg::EV_TABLE_FULL |-> m_tdata == '0)
		else $error("table full result with nonzero id");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

endmodule

bind virtual_timer_multiplexer vtm_checker u_vtm_checker (.*);

// ----- verif/tb_virtual_timer_multiplexer.sv -----
// Self-checking testbench for virtual_timer_multiplexer: start, cancel and tick items
// are checked against a slot-table predictor kept inside this module.
// Depends on vtm_pkg and the RTL of the block.
module tb_virtual_timer_multiplexer;
	timeunit 1ns;
	timeprecision 1ps;

	import vtm_pkg::*;

	localparam int NUM_SLOTS = NUM_SLOTS_DEF;
	localparam int TIME_BITS = TIME_BITS_DEF;
	localparam logic [TIME_BITS-1:0] HALF_RANGE = {1'b1, {(TIME_BITS-1){1'b0}}};
	localparam int RANDOM_REQUESTS = 256;
	localparam int SETTLE_CYCLES = 4 * (NUM_SLOTS + 6) + 12;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct {
		action_t        action;
		logic [DUR_W-1:0] duration;
		logic [ID_W-1:0]  target_id;
	} timer_request_t;

	typedef struct {
		event_t          kind;
		logic [ID_W-1:0] id;
		logic            last;
	} timer_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [ACT_W-1:0] s_tuser = ACT_TICK;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0] m_tuser;
	logic m_tlast;

	timer_request_t queued_requests[$];
	timer_event_t predicted_events[$];
	timer_request_t on_bus;
	timer_event_t want;
	int total_requests = 0;
	int accepted_requests = 0;
	int failures = 0;
	int cycle_count = 0;
	int send_idle_pct = 32;
	int stall_pct = 50;

	// Shadow copy of the timer state.
	logic [TIME_BITS-1:0] now_us = '0;
	bit slot_armed [NUM_SLOTS];
	bit slot_periodic [NUM_SLOTS];
	logic [TIME_BITS-1:0] slot_period_us [NUM_SLOTS];
	logic [TIME_BITS-1:0] slot_due_at [NUM_SLOTS];

	virtual_timer_multiplexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	// Updates the shadow state for one accepted item and queues the events it causes.
	function automatic void apply_request(input timer_request_t req);
		int i;
		int k;
		int free_slot;
		int pick;
		bit fire_now [NUM_SLOTS];
		logic [TIME_BITS-1:0] overdue [NUM_SLOTS];
		int fire_order[$];
		timer_event_t ev;
		free_slot = -1;
		ev.last = 1'b1;
		case (req.action)
			ACT_START_ONCE, ACT_START_REPEAT: begin
				for (i = NUM_SLOTS - 1; i >= 0; i--)
					if (!slot_armed[i])
						free_slot = i;
				if (free_slot < 0) begin
					ev.kind = EV_TABLE_FULL;
					ev.id = '0;
				end else begin
					slot_armed[free_slot] = 1'b1;
					slot_periodic[free_slot] = (req.action == ACT_START_REPEAT);
					slot_period_us[free_slot] = req.duration;
					slot_due_at[free_slot] = now_us + req.duration;
					ev.kind = EV_STARTED;
					ev.id = free_slot[ID_W-1:0];
				end
				predicted_events.push_back(ev);
			end
			ACT_CANCEL: begin
				if (req.target_id < NUM_SLOTS && slot_armed[req.target_id]) begin
					slot_armed[req.target_id] = 1'b0;
					slot_periodic[req.target_id] = 1'b0;
					ev.kind = EV_CANCELLED;
				end else begin
					ev.kind = EV_NOT_FOUND;
				end
				ev.id = req.target_id;
				predicted_events.push_back(ev);
			end
			default: begin
				// Tick: every due slot fires once, most overdue first, lower index on a tie.
				now_us = now_us + 1'b1;
				for (i = 0; i < NUM_SLOTS; i++) begin
					overdue[i] = now_us - slot_due_at[i];
					fire_now[i] = slot_armed[i] && (overdue[i] < HALF_RANGE);
				end
				pick = 0;
				while (pick >= 0) begin
					pick = -1;
					for (i = 0; i < NUM_SLOTS; i++)
						if (fire_now[i] && (pick < 0 || overdue[i] > overdue[pick]))
							pick = i;
					if (pick >= 0) begin
						fire_now[pick] = 1'b0;
						fire_order.push_back(pick);
						if (slot_periodic[pick])
							slot_due_at[pick] = slot_due_at[pick] + slot_period_us[pick];
						else
							slot_armed[pick] = 1'b0;
					end
				end
				for (k = 0; k < fire_order.size(); k++) begin
					ev.kind = EV_EXPIRED;
					ev.id = fire_order[k][ID_W-1:0];
					ev.last = (k == fire_order.size() - 1);
					predicted_events.push_back(ev);
				end
			end
		endcase
	endfunction

	task automatic queue_request(input action_t action, input logic [DUR_W-1:0] duration,
			input logic [ID_W-1:0] target_id);
		timer_request_t req;
		req.action = action;
		req.duration = duration;
		req.target_id = target_id;
		queued_requests.push_back(req);
	endtask

	// Mostly short delays so that timers really expire; the rest spans the whole range,
	// with a cluster around the half-range point where the due test flips.
	function automatic logic [DUR_W-1:0] random_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		else if (r < 70)
			return DUR_W'($urandom_range(1, 24));
		else if (r < 80)
			return DUR_W'($urandom_range(25, 400));
		else if (r < 90)
			return $urandom;
		else
			return 32'h7FFF_FFF8 + DUR_W'($urandom_range(0, 15));
	endfunction

	// Sender: holds an item until it is taken, and idles between items at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_request(on_bus);
				accepted_requests <= accepted_requests + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					on_bus = queued_requests.pop_front();
					s_tuser <= on_bus.action;
					s_tdata <= {4'b0000, on_bus.target_id, on_bus.duration};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Result checker: every accepted result must match the oldest predicted event.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_events.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d tdata 0x%02h last %0b",
					$time, m_tuser, m_tdata, m_tlast);
				failures++;
			end else begin
				want = predicted_events.pop_front();
				if (m_tuser !== want.kind || m_tdata !== {4'b0000, want.id} ||
						m_tlast !== want.last) begin
					$display("%0t: result mismatch, expected kind %0d id %0d last %0b, got kind %0d tdata 0x%02h last %0b",
						$time, want.kind, want.id, want.last, m_tuser, m_tdata, m_tlast);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("virtual_timer_multiplexer regression: fail");
			$finish;
		end
	end

	initial begin
		int k;
		int mode;
		int run_len;
		int tick_pct;
		int r;
		// Directed part: cancel on an empty table, extreme delays, zero period,
		// a full table, ties between slots, and a cancel of an expired one-shot.
		queue_request(ACT_CANCEL, 32'h0, 4'd15);
		queue_request(ACT_START_ONCE, 32'h0, 4'd0);
		queue_request(ACT_START_REPEAT, 32'h0, 4'd15);
		queue_request(ACT_START_ONCE, 32'hFFFF_FFFF, 4'd0);
		queue_request(ACT_START_ONCE, 32'h8000_0000, 4'd15);
		queue_request(ACT_START_ONCE, 32'h7FFF_FFFF, 4'd0);
		queue_request(ACT_START_REPEAT, 32'h1, 4'd15);
		queue_request(ACT_START_REPEAT, 32'h2, 4'd0);
		for (k = 7; k < NUM_SLOTS; k++)
			queue_request((k % 3 == 0) ? ACT_START_REPEAT : ACT_START_ONCE, DUR_W'(k - 4),
				ID_W'($urandom_range(0, 15)));
		queue_request(ACT_START_ONCE, 32'h5, 4'd0);
		queue_request(ACT_CANCEL, $urandom, 4'd4);
		queue_request(ACT_TICK, $urandom, 4'd9);
		queue_request(ACT_TICK, $urandom, 4'd3);
		queue_request(ACT_TICK, $urandom, 4'd12);
		queue_request(ACT_CANCEL, $urandom, 4'd1);
		queue_request(ACT_CANCEL, $urandom, 4'd0);

		// Random part in runs that either load the table, let it drain, or mix both.
		k = 0;
		while (k < RANDOM_REQUESTS) begin
			mode = $urandom_range(0, 2);
			run_len = $urandom_range(8, 24);
			if (run_len > RANDOM_REQUESTS - k)
				run_len = RANDOM_REQUESTS - k;
			tick_pct = (mode == 0) ? 25 : (mode == 1) ? 80 : 50;
			repeat (run_len) begin
				r = $urandom_range(0, 99);
				if (r < tick_pct)
					queue_request(ACT_TICK, $urandom, ID_W'($urandom));
				else if ($urandom_range(0, 99) < 25)
					queue_request(ACT_CANCEL, $urandom, ID_W'($urandom));
				else if ($urandom_range(0, 99) < 35)
					queue_request(ACT_START_REPEAT, random_duration(), ID_W'($urandom));
				else
					queue_request(ACT_START_ONCE, random_duration(), ID_W'($urandom));
				k++;
			end
		end
		total_requests = queued_requests.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Idle pattern changes by thirds of the stimulus.
		while (accepted_requests < total_requests / 3)
			@(posedge clk);
		send_idle_pct <= 50;
		stall_pct <= 32;
		while (accepted_requests < 2 * total_requests / 3)
			@(posedge clk);
		send_idle_pct <= 0;
		stall_pct <= 0;
		while (accepted_requests < total_requests)
			@(posedge clk);
		while (predicted_events.size() != 0)
			@(posedge clk);
		// A tick may still be scanning after the last predicted result, and a stray result would show here.
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (failures == 0)
			$display("virtual_timer_multiplexer regression: pass");
		else
			$display("virtual_timer_multiplexer regression: fail");
		$finish;
	end

endmodule
